### rtl/core/jac_pkg.sv
// shared constants and types of the joystick axis conditioner
package jac_pkg;

	localparam int NUM_AXES    = 4;
	localparam int NUM_SAMPLES = 5;

	localparam int ADC_W  = 12;
	localparam int AXIS_W = 8;
	localparam int BTN_W  = 7;
	localparam int MASK_W = 4;

	localparam int ADC_MAX  = 4095;
	localparam int AXIS_MAX = 255;
	localparam int MAP_LO_SCALE = 127;
	localparam int MAP_HI_SCALE = 128;
	localparam int MAP_OFFSET   = 127;

	// sample sum and frame count widths follow the frame length
	localparam int SUM_W = $clog2(NUM_SAMPLES * ADC_MAX + 1);
	localparam int CNT_W = $clog2(NUM_SAMPLES + 1);

	// frame average by reciprocal multiply, exact over the full sum range
	localparam int AVG_SHIFT  = $clog2(NUM_SAMPLES * NUM_SAMPLES * ADC_MAX + 1);
	localparam int AVG_RECIP  = ((1 << AVG_SHIFT) + NUM_SAMPLES - 1) / NUM_SAMPLES;
	localparam int AVG_PROD_W = SUM_W + $clog2(AVG_RECIP + 1);

	// avg*255/4095 reduces to avg*17/273, also taken by reciprocal multiply
	localparam int SCALE_NUM    = 17;
	localparam int SCALE_DEN    = 273;
	localparam int SCALE_SHIFT  = 25;
	localparam int SCALE_RECIP  = ((1 << SCALE_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
	localparam int SCALE_T_W    = $clog2(ADC_MAX * SCALE_NUM + 1);
	localparam int SCALE_PROD_W = SCALE_T_W + $clog2(SCALE_RECIP + 1);

	// serial divider for the center mapping: widest dividend is (r-c)*128,
	// widest divisor is 255
	localparam int DIV_NUM_W = $clog2(AXIS_MAX * MAP_HI_SCALE + 1);
	localparam int DIV_DEN_W = AXIS_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	localparam logic [AXIS_W-1:0] CENTER_RESET    = 8'd127;
	localparam logic [AXIS_W-1:0] PREV_AXIS_RESET = 8'd127;
	localparam logic [AXIS_W-1:0] THRESH_RESET    = 8'd5;
	localparam logic [MASK_W-1:0] INVERT_RESET    = 4'd0;
	localparam logic [BTN_W-1:0]  PREV_BTN_RESET  = 7'h7F;
	// R1, R2, LB, RB and switch
	localparam logic [BTN_W-1:0]  SEND_BTN_MASK   = 7'h73;

	// register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_CENTER_LX = 3'd0;
	localparam logic [2:0] REG_CENTER_LY = 3'd1;
	localparam logic [2:0] REG_CENTER_RX = 3'd2;
	localparam logic [2:0] REG_CENTER_RY = 3'd3;
	localparam logic [2:0] REG_INVERT    = 3'd4;
	localparam logic [2:0] REG_THRESHOLD = 3'd5;

	typedef struct packed {
		logic acc;     // item accepted
		logic last;    // item closes the frame
		logic commit;  // frame result taken into the output register
	} lane_ctrl_t;

	typedef struct packed {
		logic              done;
		logic              exceed;
		logic [AXIS_W-1:0] value;
	} lane_stat_t;

endpackage

### rtl/core/joystick_axis_conditioner_core.sv
// joystick axis conditioner top level: config registers, frame control, lanes
// an item that closes a frame starts the lane computation: its sum is registered,
// averaged and scaled by reciprocal multiply, then divided serially per lane
// other items are accepted whenever intake is open
// input is held off from a frame's last item until its result is registered
// reset: asynchronous, active low; centers 127, no invert, threshold 5, sums cleared
module joystick_axis_conditioner_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [jac_pkg::ADDR_W-1:0]   paddr,
	input  logic [jac_pkg::DATA_W-1:0]   pwdata,
	output logic [jac_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [jac_pkg::ADC_W-1:0]    sample_lx,
	input  logic [jac_pkg::ADC_W-1:0]    sample_ly,
	input  logic [jac_pkg::ADC_W-1:0]    sample_rx,
	input  logic [jac_pkg::ADC_W-1:0]    sample_ry,
	input  logic [jac_pkg::BTN_W-1:0]    button_bits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [jac_pkg::AXIS_W-1:0]   axis_lx,
	output logic [jac_pkg::AXIS_W-1:0]   axis_ly,
	output logic [jac_pkg::AXIS_W-1:0]   axis_rx,
	output logic [jac_pkg::AXIS_W-1:0]   axis_ry,
	output logic [jac_pkg::BTN_W-1:0]    buttons_out,
	output logic                         send_flag
);

	localparam logic S_ACC = 1'b0;
	localparam logic S_RUN = 1'b1;

	logic                                               state_q;
	logic [jac_pkg::CNT_W-1:0]                          cnt_q;
	logic [jac_pkg::NUM_AXES-1:0][jac_pkg::AXIS_W-1:0]  center_q;
	logic [jac_pkg::MASK_W-1:0]                         invert_q;
	logic [jac_pkg::AXIS_W-1:0]                         thresh_q;

	logic                                               wr_en;
	logic [2:0]                                         reg_idx;
	logic                                               accept;
	logic                                               last;
	logic                                               all_done;
	logic                                               load;
	jac_pkg::lane_ctrl_t                                ctrl;
	jac_pkg::lane_stat_t [jac_pkg::NUM_AXES-1:0]        lane_stat;
	logic [jac_pkg::NUM_AXES-1:0][jac_pkg::ADC_W-1:0]   samples;
	logic [jac_pkg::NUM_AXES-1:0][jac_pkg::AXIS_W-1:0]  axes;
	logic [jac_pkg::NUM_AXES-1:0]                       lane_done;

	// register port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < jac_pkg::NUM_AXES; i++) begin
				center_q[i] <= jac_pkg::CENTER_RESET;
			end
			invert_q <= jac_pkg::INVERT_RESET;
			thresh_q <= jac_pkg::THRESH_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				jac_pkg::REG_CENTER_LX: center_q[0] <= pwdata[jac_pkg::AXIS_W-1:0];
				jac_pkg::REG_CENTER_LY: center_q[1] <= pwdata[jac_pkg::AXIS_W-1:0];
				jac_pkg::REG_CENTER_RX: center_q[2] <= pwdata[jac_pkg::AXIS_W-1:0];
				jac_pkg::REG_CENTER_RY: center_q[3] <= pwdata[jac_pkg::AXIS_W-1:0];
				jac_pkg::REG_INVERT:    invert_q    <= pwdata[jac_pkg::MASK_W-1:0];
				jac_pkg::REG_THRESHOLD: thresh_q    <= pwdata[jac_pkg::AXIS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			jac_pkg::REG_CENTER_LX: prdata = jac_pkg::DATA_W'(center_q[0]);
			jac_pkg::REG_CENTER_LY: prdata = jac_pkg::DATA_W'(center_q[1]);
			jac_pkg::REG_CENTER_RX: prdata = jac_pkg::DATA_W'(center_q[2]);
			jac_pkg::REG_CENTER_RY: prdata = jac_pkg::DATA_W'(center_q[3]);
			jac_pkg::REG_INVERT:    prdata = jac_pkg::DATA_W'(invert_q);
			jac_pkg::REG_THRESHOLD: prdata = jac_pkg::DATA_W'(thresh_q);
			default:                prdata = '0;
		endcase
	end

	// frame control
	assign in_ready = state_q == S_ACC;
	assign accept   = in_valid && in_ready;
	assign last     = cnt_q == jac_pkg::CNT_W'(jac_pkg::NUM_SAMPLES - 1);

	always_comb begin
		for (int i = 0; i < jac_pkg::NUM_AXES; i++) begin
			lane_done[i] = lane_stat[i].done;
		end
	end

	assign all_done = &lane_done;
	// result moves into the output register once that one is free
	assign load     = (state_q == S_RUN) && all_done && (!out_valid || out_ready);

	assign ctrl.acc    = accept;
	assign ctrl.last   = last;
	assign ctrl.commit = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_ACC: begin
					if (accept) begin
						if (last) begin
							cnt_q   <= '0;
							state_q <= S_RUN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_RUN: begin
					if (load) begin
						state_q <= S_ACC;
					end
				end
				default: begin
					state_q <= S_ACC;
				end
			endcase
		end
	end

	assign samples[0] = sample_lx;
	assign samples[1] = sample_ly;
	assign samples[2] = sample_rx;
	assign samples[3] = sample_ry;

	for (genvar g = 0; g < jac_pkg::NUM_AXES; g++) begin : g_lane
		jac_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.sample    (samples[g]),
			.center    (center_q[g]),
			.invert    (invert_q[g]),
			.threshold (thresh_q),
			.stat      (lane_stat[g])
		);
	end

	jac_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.cap_btn     (accept && last),
		.button_bits (button_bits),
		.load        (load),
		.lane_stat   (lane_stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.axes        (axes),
		.buttons     (buttons_out),
		.send        (send_flag)
	);

	assign axis_lx = axes[0];
	assign axis_ly = axes[1];
	assign axis_rx = axes[2];
	assign axis_ry = axes[3];

endmodule

### rtl/core/jac_div.sv
// restoring serial divider, one quotient bit per cycle
module jac_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [jac_pkg::DIV_NUM_W-1:0]  num,
	input  logic [jac_pkg::DIV_DEN_W-1:0]  den,
	output logic                           done,
	output logic [jac_pkg::DIV_NUM_W-1:0]  quo
);

	logic                          busy_q;
	logic                          done_q;
	logic [jac_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [jac_pkg::DIV_NUM_W-1:0] quo_q;
	logic [jac_pkg::DIV_DEN_W-1:0] rem_q;
	logic [jac_pkg::DIV_DEN_W-1:0] den_q;
	logic [jac_pkg::DIV_DEN_W:0]   shifted;
	logic [jac_pkg::DIV_DEN_W:0]   diff;
	logic                          fits;

	assign shifted = {rem_q, quo_q[jac_pkg::DIV_NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == jac_pkg::DIV_CNT_W'(jac_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[jac_pkg::DIV_NUM_W-2:0], fits};
			rem_q <= fits ? diff[jac_pkg::DIV_DEN_W-1:0] : shifted[jac_pkg::DIV_DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/jac_lane.sv
// one axis lane: sample sum, average, scale, center mapping and inversion, change test
module jac_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jac_pkg::lane_ctrl_t         ctrl,
	input  logic [jac_pkg::ADC_W-1:0]   sample,
	input  logic [jac_pkg::AXIS_W-1:0]  center,
	input  logic                        invert,
	input  logic [jac_pkg::AXIS_W-1:0]  threshold,
	output jac_pkg::lane_stat_t         stat
);

	localparam logic [2:0] L_IDLE  = 3'd0;
	localparam logic [2:0] L_AVG   = 3'd1;
	localparam logic [2:0] L_SCALE = 3'd2;
	localparam logic [2:0] L_START = 3'd3;
	localparam logic [2:0] L_MAP   = 3'd4;
	localparam logic [2:0] L_DONE  = 3'd5;

	logic [2:0]                      state_q;
	logic [jac_pkg::SUM_W-1:0]       sum_q;
	logic [jac_pkg::SUM_W-1:0]       sum_next;
	logic [jac_pkg::SUM_W-1:0]       tot_q;
	logic [jac_pkg::ADC_W-1:0]       avg_q;
	logic [jac_pkg::AXIS_W-1:0]      scl_q;
	logic [jac_pkg::AXIS_W-1:0]      prev_q;
	logic [jac_pkg::AXIS_W-1:0]      val_q;
	logic                            lo_q;
	logic                            c255_q;

	logic [jac_pkg::AVG_PROD_W-1:0]   avg_prod;
	logic [jac_pkg::SCALE_T_W-1:0]    scl_t;
	logic [jac_pkg::SCALE_PROD_W-1:0] scl_prod;

	logic                            div_start;
	logic [jac_pkg::DIV_NUM_W-1:0]   div_num;
	logic [jac_pkg::DIV_DEN_W-1:0]   div_den;
	logic                            div_done;
	logic [jac_pkg::DIV_NUM_W-1:0]   div_quo;

	logic [jac_pkg::AXIS_W-1:0]      r;
	logic                            lo;
	logic [jac_pkg::DIV_NUM_W:0]     hi_sum;
	logic [jac_pkg::AXIS_W-1:0]      mapped;
	logic [jac_pkg::AXIS_W-1:0]      vout;
	logic [jac_pkg::AXIS_W-1:0]      delta;

	assign sum_next = sum_q + jac_pkg::SUM_W'(sample);

	// frame average, then avg*255/4095 as avg*17/273
	assign avg_prod = jac_pkg::AVG_PROD_W'(tot_q) * jac_pkg::AVG_PROD_W'(jac_pkg::AVG_RECIP);
	assign scl_t    = jac_pkg::SCALE_T_W'(avg_q) * jac_pkg::SCALE_T_W'(jac_pkg::SCALE_NUM);
	assign scl_prod = jac_pkg::SCALE_PROD_W'(scl_t)
		* jac_pkg::SCALE_PROD_W'(jac_pkg::SCALE_RECIP);

	assign r  = jac_pkg::AXIS_W'(jac_pkg::AXIS_MAX) - scl_q;
	assign lo = r < center;

	always_comb begin
		div_start = state_q == L_START;
		if (lo) begin
			div_num = jac_pkg::DIV_NUM_W'(r) * jac_pkg::DIV_NUM_W'(jac_pkg::MAP_LO_SCALE);
			div_den = jac_pkg::DIV_DEN_W'(center);
		end else begin
			div_num = jac_pkg::DIV_NUM_W'(r - center)
				* jac_pkg::DIV_NUM_W'(jac_pkg::MAP_HI_SCALE);
			div_den = jac_pkg::DIV_DEN_W'(jac_pkg::AXIS_W'(jac_pkg::AXIS_MAX) - center);
		end
	end

	jac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// final value: lower branch is the quotient, upper adds the center offset (offset alone if center is 255)
	assign hi_sum = {1'b0, div_quo} + (jac_pkg::DIV_NUM_W + 1)'(jac_pkg::MAP_OFFSET);

	always_comb begin
		if (lo_q) begin
			mapped = (div_quo > jac_pkg::DIV_NUM_W'(jac_pkg::AXIS_MAX))
				? jac_pkg::AXIS_W'(jac_pkg::AXIS_MAX) : div_quo[jac_pkg::AXIS_W-1:0];
		end else if (c255_q) begin
			mapped = jac_pkg::AXIS_W'(jac_pkg::MAP_OFFSET);
		end else begin
			mapped = (hi_sum > (jac_pkg::DIV_NUM_W + 1)'(jac_pkg::AXIS_MAX))
				? jac_pkg::AXIS_W'(jac_pkg::AXIS_MAX) : hi_sum[jac_pkg::AXIS_W-1:0];
		end
		vout = invert ? jac_pkg::AXIS_W'(jac_pkg::AXIS_MAX) - mapped : mapped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			sum_q   <= '0;
			prev_q  <= jac_pkg::PREV_AXIS_RESET;
		end else begin
			if (ctrl.acc) begin
				sum_q <= ctrl.last ? '0 : sum_next;
			end
			case (state_q)
				L_IDLE: begin
					if (ctrl.acc && ctrl.last) begin
						state_q <= L_AVG;
					end
				end
				L_AVG: begin
					state_q <= L_SCALE;
				end
				L_SCALE: begin
					state_q <= L_START;
				end
				L_START: begin
					state_q <= L_MAP;
				end
				L_MAP: begin
					if (div_done) begin
						state_q <= L_DONE;
					end
				end
				L_DONE: begin
					if (ctrl.commit) begin
						prev_q  <= val_q;
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && ctrl.acc && ctrl.last) begin
			tot_q <= sum_next;
		end
		if (state_q == L_AVG) begin
			avg_q <= avg_prod[jac_pkg::AVG_SHIFT +: jac_pkg::ADC_W];
		end
		if (state_q == L_SCALE) begin
			scl_q <= scl_prod[jac_pkg::SCALE_SHIFT +: jac_pkg::AXIS_W];
		end
		if (state_q == L_START) begin
			lo_q   <= lo;
			c255_q <= center == jac_pkg::AXIS_W'(jac_pkg::AXIS_MAX);
		end
		if (state_q == L_MAP && div_done) begin
			val_q <= vout;
		end
	end

	assign delta = (val_q > prev_q) ? val_q - prev_q : prev_q - val_q;

	assign stat.done   = state_q == L_DONE;
	assign stat.exceed = delta > threshold;
	assign stat.value  = val_q;

endmodule

### rtl/core/jac_merge.sv
// merge of lane results with the button test into the output register
module jac_merge (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cap_btn,
	input  logic [jac_pkg::BTN_W-1:0]                     button_bits,
	input  logic                                          load,
	input  jac_pkg::lane_stat_t [jac_pkg::NUM_AXES-1:0]   lane_stat,
	input  logic                                          out_ready,
	output logic                                          out_valid,
	output logic [jac_pkg::NUM_AXES-1:0][jac_pkg::AXIS_W-1:0] axes,
	output logic [jac_pkg::BTN_W-1:0]                     buttons,
	output logic                                          send
);

	logic                                               out_valid_q;
	logic [jac_pkg::BTN_W-1:0]                          btn_q;
	logic [jac_pkg::BTN_W-1:0]                          prev_btn_q;
	logic [jac_pkg::NUM_AXES-1:0][jac_pkg::AXIS_W-1:0]  axes_q;
	logic [jac_pkg::BTN_W-1:0]                          btns_q;
	logic                                               send_q;
	logic [jac_pkg::NUM_AXES-1:0]                       exceed;
	logic                                               btn_change;

	always_comb begin
		for (int i = 0; i < jac_pkg::NUM_AXES; i++) begin
			exceed[i] = lane_stat[i].exceed;
		end
	end

	assign btn_change = ((btn_q ^ prev_btn_q) & jac_pkg::SEND_BTN_MASK) != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_btn_q  <= jac_pkg::PREV_BTN_RESET;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				prev_btn_q  <= btn_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap_btn) begin
			btn_q <= button_bits;
		end
		if (load) begin
			for (int i = 0; i < jac_pkg::NUM_AXES; i++) begin
				axes_q[i] <= lane_stat[i].value;
			end
			btns_q <= btn_q;
			send_q <= (|exceed) || btn_change;
		end
	end

	assign out_valid = out_valid_q;
	assign axes      = axes_q;
	assign buttons   = btns_q;
	assign send      = send_q;

endmodule

### rtl/core/jac_checker.sv
// port-level checks of the joystick axis conditioner, bound to the top level
module jac_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [jac_pkg::AXIS_W-1:0]  axis_lx,
	input  logic [jac_pkg::AXIS_W-1:0]  axis_ly,
	input  logic [jac_pkg::AXIS_W-1:0]  axis_rx,
	input  logic [jac_pkg::AXIS_W-1:0]  axis_ry,
	input  logic [jac_pkg::BTN_W-1:0]   buttons_out,
	input  logic                        send_flag
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(axis_lx) && $stable(axis_ly)
			&& $stable(axis_rx) && $stable(axis_ry) && $stable(buttons_out)
			&& $stable(send_flag))
		else $error("result changed while stalled");

	// intake closes only right after an accepted item
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("in_ready fell without an accepted item");

	// a new result appears only after the lanes ran with intake closed
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("result appeared outside the end of a frame computation");

	// no result right after an accepted item
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result rose right after an accepted item");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("register access stalled");

endmodule

bind joystick_axis_conditioner_core jac_checker u_jac_checker (.*);
